// ----- hdl/ucx_pkg.sv -----
// Shared types and constants for the UTF-8 unique codepoint extractor.
// Holds byte-decode masks and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ucx_pkg;

	// field widths
	localparam int CP_W   = 21;
	localparam int BYTE_W = 8;
	localparam int CONT_W = 6;

	// byte classes of lax UTF-8
	localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_TAG   = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_TAG   = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_TAG   = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_BITS  = 8'h07;
	localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;

	// continuation counts set by a lead byte
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic accept;    // take the request byte and decode it
		logic search;    // step the seen-table scan
		logic resolve;   // scan missed: insert or flag overflow
		logic load_out;  // fill the output register
	} ucx_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic dec_done;     // byte completes a codepoint
		logic last_in;      // byte on the input port is the final one
		logic hit;          // codepoint found in the table
		logic miss;         // scan ran past the filled entries
		logic emit_needed;  // current request produces a result
		logic out_free;     // output register can take a result
	} ucx_status_t;

endpackage

`default_nettype wire

// ----- hdl/ucx_ctrl.sv -----
// Controller state machine of the UTF-8 unique codepoint extractor.
// Sequences decode, table scan and result hand-off; uses ucx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucx_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire ucx_pkg::ucx_status_t status,
	output ucx_pkg::ucx_cmd_t        cmd
);
	import ucx_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// take a request only between items
	assign in_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.dec_done) begin
						state_d = ST_SEARCH;
					end else if (status.last_in) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (status.hit) begin
					state_d = ST_EMIT;
				end else if (status.miss) begin
					cmd.resolve = 1'b1;
					state_d     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!status.emit_needed) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// never accept while a scan or hand-off is in flight
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> state_q == ST_IDLE)
		else $error("request accepted outside idle");

	// a scan ends on a hit or a miss, never both
	a_hit_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> !(status.hit && status.miss))
		else $error("scan reports hit and miss together");

	// the output is loaded only when the slot is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free && status.emit_needed)
		else $error("output loaded into a busy slot");

endmodule

`default_nettype wire

// ----- hdl/ucx_datapath.sv -----
// Datapath of the UTF-8 unique codepoint extractor: byte decoder, seen-table
// memory with a sequential scan, fill count, overflow flag and output register.
// Uses ucx_pkg; driven by ucx_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ucx_datapath #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [ucx_pkg::BYTE_W-1:0] text_byte,
	input  wire logic                      last_byte,
	input  wire ucx_pkg::ucx_cmd_t         cmd,
	output ucx_pkg::ucx_status_t           status,
	output logic [ucx_pkg::CP_W-1:0]       codepoint,
	output logic                           new_codepoint,
	output logic                           end_of_text,
	output logic                           table_overflow,
	output logic                           out_valid,
	input  wire logic                      out_stall
);
	import ucx_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

	// decoder state
	logic [1:0]      bytes_pending_q;
	logic [CP_W-1:0] partial_q;
	logic [CP_W-1:0] cp_q;
	logic            last_q;
	logic            fresh_q;

	// table state
	logic [CP_W-1:0] seen_mem [TABLE_DEPTH];
	logic [CW-1:0]   count_q;
	logic            overflow_q;
	logic [CW-1:0]   srch_idx_q;
	logic            rd_vld_s1;
	logic [CP_W-1:0] rd_data_s1;

	// output register
	logic            out_valid_q;
	logic [CP_W-1:0] codepoint_q;
	logic            new_cp_q;
	logic            end_q;
	logic            ovf_out_q;

	// decode results
	logic [1:0]      pend_d;
	logic [CP_W-1:0] part_d;
	logic            dec_done;
	logic [CP_W-1:0] dec_cp;
	logic            rd_en;
	logic            hit;

	// decode one byte against the pending sequence
	always_comb begin
		pend_d   = bytes_pending_q;
		part_d   = partial_q;
		dec_done = 1'b0;
		dec_cp   = '0;
		if (bytes_pending_q != PEND_NONE) begin
			part_d = {partial_q[CP_W-CONT_W-1:0], CONT_W'(text_byte & CONT_BITS)};
			pend_d = bytes_pending_q - 2'd1;
			if (bytes_pending_q == PEND_ONE) begin
				dec_done = 1'b1;
				dec_cp   = part_d;
			end
		end else if (text_byte < ASCII_LIMIT) begin
			dec_done = 1'b1;
			dec_cp   = CP_W'(text_byte);
		end else if ((text_byte & LEAD2_MASK) == LEAD2_TAG) begin
			part_d = CP_W'(text_byte & LEAD2_BITS);
			pend_d = PEND_ONE;
		end else if ((text_byte & LEAD3_MASK) == LEAD3_TAG) begin
			part_d = CP_W'(text_byte & LEAD3_BITS);
			pend_d = PEND_TWO;
		end else if ((text_byte & LEAD4_MASK) == LEAD4_TAG) begin
			part_d = CP_W'(text_byte & LEAD4_BITS);
			pend_d = PEND_THREE;
		end
	end

	// scan compare on the registered read data
	assign rd_en = cmd.search && (srch_idx_q < count_q);
	assign hit   = rd_vld_s1 && (rd_data_s1 == cp_q);

	assign status.dec_done    = dec_done;
	assign status.last_in     = last_byte;
	assign status.hit         = hit;
	assign status.miss        = !hit && !rd_vld_s1 && (srch_idx_q >= count_q);
	assign status.emit_needed = fresh_q || last_q;
	assign status.out_free    = !out_valid_q || !out_stall;

	// seen-table memory: one read and one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= seen_mem[srch_idx_q[IW-1:0]];
		end
		if (cmd.resolve && (count_q != FULL)) begin
			seen_mem[count_q[IW-1:0]] <= cp_q;
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cp_q <= dec_cp;
		end
		if (cmd.load_out) begin
			codepoint_q <= fresh_q ? cp_q : '0;
			new_cp_q    <= fresh_q;
			end_q       <= last_q;
			ovf_out_q   <= overflow_q;
		end
	end

	// control state of decoder, scan and table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_pending_q <= PEND_NONE;
			partial_q       <= '0;
			last_q          <= 1'b0;
			fresh_q         <= 1'b0;
			count_q         <= '0;
			overflow_q      <= 1'b0;
			srch_idx_q      <= '0;
			rd_vld_s1       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			// advance the decoder and restart the scan
			if (cmd.accept) begin
				bytes_pending_q <= pend_d;
				partial_q       <= dec_done ? '0 : part_d;
				last_q          <= last_byte;
				fresh_q         <= 1'b0;
				srch_idx_q      <= '0;
				rd_vld_s1       <= 1'b0;
			end
			// step the scan one entry a cycle
			if (cmd.search) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					srch_idx_q <= srch_idx_q + CW'(1);
				end
			end
			// insert a first occurrence or drop it when full
			if (cmd.resolve) begin
				if (count_q == FULL) begin
					overflow_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
					fresh_q <= 1'b1;
				end
			end
			// hand off the result, or drop it once taken
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			// the final byte clears all text state
			if (cmd.load_out && last_q) begin
				bytes_pending_q <= PEND_NONE;
				partial_q       <= '0;
				count_q         <= '0;
				overflow_q      <= 1'b0;
			end
		end
	end

	assign codepoint      = codepoint_q;
	assign new_codepoint  = new_cp_q;
	assign end_of_text    = end_q;
	assign table_overflow = ovf_out_q;
	assign out_valid      = out_valid_q;

	// fill count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("seen count beyond table depth");

	// overflow rises only with a full table
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overflow_q) |-> count_q == FULL)
		else $error("overflow set with room left");

	// end of text leaves a cleared table and decoder
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && last_q) |=> (count_q == '0) && !overflow_q
			&& (bytes_pending_q == PEND_NONE))
		else $error("state not cleared after end of text");

	// a repeated or missing codepoint reads as zero
	a_cp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !new_cp_q) |-> codepoint_q == '0)
		else $error("codepoint nonzero without new flag");

endmodule

`default_nettype wire

// ----- hdl/utf8_unique_codepoint_extractor.sv -----
// Top level of the UTF-8 unique codepoint extractor.
// Joins the controller (ucx_ctrl) and the datapath (ucx_datapath); uses ucx_pkg.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------------
//   input    | in_valid / in_stall | text_byte[7:0], last_byte
//   output   | out_valid/out_stall | codepoint[20:0], new_codepoint, end_of_text,
//            |                     | table_overflow
//
// A byte that completes no codepoint is taken in the idle state; a last byte also passes
// through the emit state. A completed codepoint is scanned against the filled entries: a
// repeat ends the scan on a hit, a first occurrence on a miss past all filled entries.
// The table gives one registered read a cycle, so a scan grows with the entries compared.
// arst_n clears decoder, fill count and overflow; the table itself is not cleared.
// A result waits in the output register while the next request is decoded;
// a new result waits only while out_stall holds the previous one.
`timescale 1ns / 1ps
`default_nettype none

module utf8_unique_codepoint_extractor #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [20:0]      codepoint,
	output logic             new_codepoint,
	output logic             end_of_text,
	output logic             table_overflow
);
	import ucx_pkg::*;

	ucx_cmd_t    cmd;
	ucx_status_t status;

	ucx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ucx_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_byte      (text_byte),
		.last_byte      (last_byte),
		.cmd            (cmd),
		.status         (status),
		.codepoint      (codepoint),
		.new_codepoint  (new_codepoint),
		.end_of_text    (end_of_text),
		.table_overflow (table_overflow),
		.out_valid      (out_valid),
		.out_stall      (out_stall)
	);

endmodule

`default_nettype wire
